// ----- rtl/core/ascii_position_velocity_estimator_macros.svh -----
// Assertion macros shared by the position and velocity estimator RTL.
// Stand-alone header; the including file supplies clock and reset names.
`ifndef ASCII_POSITION_VELOCITY_ESTIMATOR_MACROS_SVH
`define ASCII_POSITION_VELOCITY_ESTIMATOR_MACROS_SVH

// Property that must hold in the same cycle.
`define APVE_ASSERT_NOW(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// Property whose consequence is checked in the next cycle.
`define APVE_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/apve_pkg.sv -----
// Package of the ASCII position and velocity estimator: payload types,
// pipeline stage numbering, register map and fixed-point constants. No dependencies.
package apve_pkg;

  localparam int CHAR_W = 8;
  localparam logic [CHAR_W-1:0] TAG_X = 8'd88;

  localparam int POS_SAMPLE_W   = 19;
  localparam int POS_OFFSET     = 53328;
  localparam int POS_SAMPLE_MAX = 283305;
  localparam int DIG_WEIGHT_TENS   = 1000;
  localparam int DIG_WEIGHT_ONES   = 100;
  localparam int DIG_WEIGHT_TENTHS = 10;

  localparam int AVG_W    = 27;
  localparam int AVG_FRAC = 8;
  localparam int AVG_BIAS = 13651968;
  localparam int VEL_W    = 32;

  localparam int SCALE_W = 16;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd12800;

  localparam int POSITION_TAPS_DEF = 8;
  localparam int VELOCITY_TAPS_DEF = 8;

  localparam int APB_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_IDX_BIT = 2;
  localparam logic REG_SCALE = 1'b0;

  // Pipeline stage numbering, shared by the control and the lanes.
  localparam int ST_SAMPLE  = 0;
  localparam int ST_PSUM    = 1;
  localparam int ST_PDIV    = 2;
  localparam int ST_DIFF    = 5;
  localparam int ST_VMUL    = 6;
  localparam int ST_VSUM    = 7;
  localparam int ST_VDIV    = 8;
  localparam int ST_OUT     = 11;
  localparam int NUM_STAGES = 12;
  localparam int CMUL_STAGES = 3;
  localparam int AVG_DLY    = ST_OUT - ST_VMUL;

  typedef struct packed {
    logic [CHAR_W-1:0] frame_tag;
    logic [CHAR_W-1:0] x_tens_char;
    logic [CHAR_W-1:0] x_ones_char;
    logic [CHAR_W-1:0] x_tenths_char;
    logic [CHAR_W-1:0] x_hundredths_char;
    logic [CHAR_W-1:0] y_tens_char;
    logic [CHAR_W-1:0] y_ones_char;
    logic [CHAR_W-1:0] y_tenths_char;
    logic [CHAR_W-1:0] y_hundredths_char;
  } in_item_t;

  typedef struct packed {
    logic signed [AVG_W-1:0] x_position_avg;
    logic signed [AVG_W-1:0] y_position_avg;
    logic signed [VEL_W-1:0] x_velocity_avg;
    logic signed [VEL_W-1:0] y_velocity_avg;
  } out_item_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctrl_t;

endpackage

// ----- rtl/core/apve_cmul.sv -----
// Three-stage pipelined multiplier of an unsigned operand by a constant,
// built from four partial products. No dependencies.
module apve_cmul #(
  parameter int          AW   = 24,
  parameter int          MW   = 24,
  parameter logic [63:0] MVAL = 64'd1
) (
  input  logic                  clk,
  input  logic [2:0]            en,
  input  logic [AW-1:0]         a,
  output logic [AW+MW-1:0]      p
);

  localparam int AL = (AW + 1) / 2;
  localparam int AH = AW - AL;
  localparam int ML = (MW + 1) / 2;
  localparam int MH = MW - ML;
  localparam logic [ML-1:0] M_LO = MVAL[ML-1:0];
  localparam logic [MH-1:0] M_HI = MVAL[MW-1:ML];

  logic [AL+ML-1:0] pp0_r;
  logic [AL+MH-1:0] pp1_r;
  logic [AH+ML-1:0] pp2_r;
  logic [AH+MH-1:0] pp3_r;
  logic [AL+MW-1:0] lo_r, lo_nxt;
  logic [AH+MW-1:0] hi_r, hi_nxt;
  logic [AW+MW-1:0] p_r, p_nxt;

  always_comb begin
    lo_nxt = (AL+MW)'(pp0_r) + ((AL+MW)'(pp1_r) << ML);
    hi_nxt = (AH+MW)'(pp2_r) + ((AH+MW)'(pp3_r) << ML);
    p_nxt  = (AW+MW)'(lo_r) + ((AW+MW)'(hi_r) << AL);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pp0_r <= a[AL-1:0] * M_LO;
      pp1_r <= a[AL-1:0] * M_HI;
      pp2_r <= a[AW-1:AL] * M_LO;
      pp3_r <= a[AW-1:AL] * M_HI;
    end
    if (en[1]) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
    if (en[2]) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

// ----- rtl/core/apve_lane.sv -----
// One axis lane: digit decode, position window, averaging, velocity and its window.
// Depends on apve_pkg and apve_cmul.
module apve_lane import apve_pkg::*; #(
  parameter int PT = POSITION_TAPS_DEF,
  parameter int VT = VELOCITY_TAPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pipe_ctrl_t              ctrl,
  input  logic [3:0][CHAR_W-1:0]  digits,
  input  logic [SCALE_W-1:0]      scale,
  output logic signed [AVG_W-1:0] pos_avg,
  output logic signed [VEL_W-1:0] vel_avg
);

  localparam int PS_S   = $clog2(PT);
  localparam int PSUM_W = $clog2(PT * POS_SAMPLE_MAX + 1);
  localparam int PK     = PSUM_W + AVG_FRAC + PS_S;
  localparam logic [63:0] PM = ((64'd1 << PK) + 64'(PT) - 64'd1) / 64'(PT);
  localparam int PMW    = PK - PS_S + 1;
  localparam logic [PSUM_W-1:0] PSUM_RST = PSUM_W'(PT * POS_OFFSET);

  localparam int VS_S   = $clog2(VT);
  localparam int VSUM_W = VEL_W + VS_S;
  localparam int VK     = VSUM_W + VS_S;
  localparam logic [63:0] VM = ((64'd1 << VK) + 64'(VT) - 64'd1) / 64'(VT);
  localparam int VMW    = VSUM_W + 1;
  localparam logic [VSUM_W-1:0] VSUM_RST = VSUM_W'(64'(VT) << (VEL_W - 1));
  localparam logic [VEL_W-1:0]  VSAMP_ZERO = {1'b1, {(VEL_W-1){1'b0}}};

  localparam int DIFF_W  = AVG_W + 1;
  localparam int VPROD_W = DIFF_W + SCALE_W + 1;
  localparam int RAW_W   = VPROD_W - AVG_FRAC;

  logic [POS_SAMPLE_W-1:0] s_r, s_nxt;
  logic [POS_SAMPLE_W-1:0] pwin_r [PT];
  logic [PSUM_W-1:0]       psum_r, psum_nxt;
  logic [PSUM_W+PMW-1:0]   pprod;
  logic [AVG_W-1:0]        q_pos;
  logic signed [AVG_W-1:0] avg_nxt;
  logic signed [AVG_W-1:0] prev_r;
  logic signed [DIFF_W-1:0] diff_r, diff_nxt;
  logic signed [VPROD_W-1:0] vprod_r, vprod_nxt;
  logic signed [RAW_W-1:0] raw;
  logic [VEL_W-1:0]        sat;
  logic [VEL_W-1:0]        vsamp;
  logic [VEL_W-1:0]        vwin_r [VT];
  logic [VSUM_W-1:0]       vsum_r, vsum_nxt;
  logic [VSUM_W+VMW-1:0]   vprod2;
  logic [VEL_W-1:0]        vq;
  logic signed [AVG_W-1:0] avg_d_r [AVG_DLY];

  always_comb begin
    s_nxt = POS_SAMPLE_W'(digits[3]) * POS_SAMPLE_W'(DIG_WEIGHT_TENS)
          + POS_SAMPLE_W'(digits[2]) * POS_SAMPLE_W'(DIG_WEIGHT_ONES)
          + POS_SAMPLE_W'(digits[1]) * POS_SAMPLE_W'(DIG_WEIGHT_TENTHS)
          + POS_SAMPLE_W'(digits[0]);
    psum_nxt = psum_r + PSUM_W'(s_r) - PSUM_W'(pwin_r[PT-1]);
    q_pos    = pprod[PK-AVG_FRAC +: AVG_W];
    avg_nxt  = $signed(q_pos - AVG_W'(AVG_BIAS));
    diff_nxt = $signed({avg_nxt[AVG_W-1], avg_nxt}) - $signed({prev_r[AVG_W-1], prev_r});
    vprod_nxt = diff_r * $signed({1'b0, scale});
    raw = vprod_r[VPROD_W-1:AVG_FRAC];
    if ((&raw[RAW_W-1:VEL_W-1]) || !(|raw[RAW_W-1:VEL_W-1])) begin
      sat = raw[VEL_W-1:0];
    end else if (raw[RAW_W-1]) begin
      sat = {1'b1, {(VEL_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(VEL_W-1){1'b1}}};
    end
    vsamp    = {~sat[VEL_W-1], sat[VEL_W-2:0]};
    vsum_nxt = vsum_r + VSUM_W'(vsamp) - VSUM_W'(vwin_r[VT-1]);
    vq       = vprod2[VK +: VEL_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PT; i++) begin
        pwin_r[i] <= POS_SAMPLE_W'(POS_OFFSET);
      end
      for (int i = 0; i < VT; i++) begin
        vwin_r[i] <= VSAMP_ZERO;
      end
      psum_r <= PSUM_RST;
      vsum_r <= VSUM_RST;
      prev_r <= '0;
    end else begin
      if (ctrl.load[ST_PSUM]) begin
        pwin_r[0] <= s_r;
        for (int i = 1; i < PT; i++) begin
          pwin_r[i] <= pwin_r[i-1];
        end
        psum_r <= psum_nxt;
      end
      if (ctrl.load[ST_DIFF]) begin
        prev_r <= avg_nxt;
      end
      if (ctrl.load[ST_VSUM]) begin
        vwin_r[0] <= vsamp;
        for (int i = 1; i < VT; i++) begin
          vwin_r[i] <= vwin_r[i-1];
        end
        vsum_r <= vsum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[ST_SAMPLE]) begin
      s_r <= s_nxt;
    end
    if (ctrl.load[ST_DIFF]) begin
      diff_r <= diff_nxt;
    end
    if (ctrl.load[ST_VMUL]) begin
      vprod_r    <= vprod_nxt;
      avg_d_r[0] <= prev_r;
    end
    for (int i = 1; i < AVG_DLY; i++) begin
      if (ctrl.load[ST_VMUL+i]) begin
        avg_d_r[i] <= avg_d_r[i-1];
      end
    end
  end

  apve_cmul #(
    .AW   (PSUM_W),
    .MW   (PMW),
    .MVAL (PM)
  ) u_pos_div (
    .clk (clk),
    .en  (ctrl.load[ST_PDIV +: CMUL_STAGES]),
    .a   (psum_r),
    .p   (pprod)
  );

  apve_cmul #(
    .AW   (VSUM_W),
    .MW   (VMW),
    .MVAL (VM)
  ) u_vel_div (
    .clk (clk),
    .en  (ctrl.load[ST_VDIV +: CMUL_STAGES]),
    .a   (vsum_r),
    .p   (vprod2)
  );

  assign pos_avg = avg_d_r[AVG_DLY-1];
  assign vel_avg = $signed({~vq[VEL_W-1], vq[VEL_W-2:0]});

endmodule

// ----- rtl/core/apve_ctrl.sv -----
// Pipeline control: per-stage valid bits, bubble-collapsing stall logic and load enables.
// Depends on apve_pkg and the assertion macro header.
`include "ascii_position_velocity_estimator_macros.svh"

module apve_ctrl import apve_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       tag_ok,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  output pipe_ctrl_t ctrl
);

  logic [NUM_STAGES-1:0] v_r, v_nxt;
  logic [NUM_STAGES:0]   stage_rdy;
  logic [NUM_STAGES-1:0] vin;

  always_comb begin
    stage_rdy[NUM_STAGES] = out_ready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      stage_rdy[i] = !v_r[i] || stage_rdy[i+1];
    end
    vin = {v_r[NUM_STAGES-2:0], in_valid && tag_ok};
    ctrl.load = stage_rdy[NUM_STAGES-1:0] & vin;
    for (int i = 0; i < NUM_STAGES; i++) begin
      v_nxt[i] = stage_rdy[i] ? vin[i] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = stage_rdy[0];
  assign out_valid = v_r[NUM_STAGES-1];

  `APVE_ASSERT_NEXT(a_count_up, clk, rst_n, in_valid && in_ready && tag_ok && !(out_valid && out_ready), $countones(v_r) == $past($countones(v_r)) + 1, "Accepted frame not held in the pipeline.")
  `APVE_ASSERT_NEXT(a_count_down, clk, rst_n, out_valid && out_ready && !(in_valid && in_ready && tag_ok), $countones(v_r) + 1 == $past($countones(v_r)), "Result transfer did not free a stage.")
  `APVE_ASSERT_NOW(a_full_stall, clk, rst_n, !in_ready |-> ((&v_r) && !out_ready), "Input stalled while the pipeline had room.")

endmodule

// ----- rtl/core/ascii_position_velocity_estimator.sv -----
// Top level of the ASCII position and velocity estimator: APB register, two axis lanes,
// pipeline control and the merging output register. Depends on apve_pkg, apve_ctrl, apve_lane.
//
// Channel  Dir  Handshake             Payload
// in       in   in_valid / in_ready   in_data (in_item_t)
// out      out  out_valid / out_ready out_data (out_item_t)
// cfg      in   psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// One frame is taken every cycle unless the pipeline is full and the output stalls.
// Results come from the twelve-stage lane pipeline, including two three-stage dividers.
// Frames whose tag is not 'X' are taken and dropped without entering the pipeline.
// Reset is synchronous and clears the windows at once; no clearing pass follows it.
// A stalled output holds only the stages behind it that are full; empty stages still fill.
module ascii_position_velocity_estimator import apve_pkg::*; #(
  parameter int POSITION_TAPS = POSITION_TAPS_DEF,
  parameter int VELOCITY_TAPS = VELOCITY_TAPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [SCALE_W-1:0] scale_r;
  pipe_ctrl_t         ctrl;
  logic               tag_ok;
  logic signed [AVG_W-1:0] x_pos, y_pos;
  logic signed [VEL_W-1:0] x_vel, y_vel;
  out_item_t          out_r, out_nxt;

  assign pready = 1'b1;
  assign tag_ok = (in_data.frame_tag == TAG_X);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[CFG_IDX_BIT] == REG_SCALE)) begin
      scale_r <= pwdata[SCALE_W-1:0];
    end
  end

  always_comb begin
    if (paddr[CFG_IDX_BIT] == REG_SCALE) begin
      prdata = APB_DATA_W'(scale_r);
    end else begin
      prdata = '0;
    end
  end

  apve_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .tag_ok    (tag_ok),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  apve_lane #(
    .PT (POSITION_TAPS),
    .VT (VELOCITY_TAPS)
  ) u_lane_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .digits  ({in_data.x_tens_char, in_data.x_ones_char,
               in_data.x_tenths_char, in_data.x_hundredths_char}),
    .scale   (scale_r),
    .pos_avg (x_pos),
    .vel_avg (x_vel)
  );

  apve_lane #(
    .PT (POSITION_TAPS),
    .VT (VELOCITY_TAPS)
  ) u_lane_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .digits  ({in_data.y_tens_char, in_data.y_ones_char,
               in_data.y_tenths_char, in_data.y_hundredths_char}),
    .scale   (scale_r),
    .pos_avg (y_pos),
    .vel_avg (y_vel)
  );

  always_comb begin
    out_nxt.x_position_avg = x_pos;
    out_nxt.y_position_avg = y_pos;
    out_nxt.x_velocity_avg = x_vel;
    out_nxt.y_velocity_avg = y_vel;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[ST_OUT]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

// ----- tb/sv/apve_estimate_checker.sv -----
`timescale 1ns / 100ps
// Checker for the ASCII position and velocity estimator: watches the frame, estimate and
// register ports, predicts each estimate and compares it field by field. Depends on apve_pkg.
module apve_estimate_checker import apve_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int                    mismatch_count,
  output int                    outstanding,
  output int                    estimates_checked,
  output int                    saturated_samples
);

  localparam int PTAPS = POSITION_TAPS_DEF;
  localparam int VTAPS = VELOCITY_TAPS_DEF;
  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int ASCII_ZERO = 48;
  localparam int FRAC_SCALE = 256;
  localparam longint VEL_MAX = 64'sd2147483647;
  localparam longint VEL_MIN = -64'sd2147483648;

  int pos_win [2][PTAPS];
  int vel_win [2][VTAPS];
  int prev_avg [2];
  logic [SCALE_W-1:0] rate_scale;
  out_item_t estimate_queue [$];
  int errors;
  int checked;
  int saturated;

  task automatic report_mismatch(input string msg);
    $display("[%0t] estimate mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic longint floor_div(input longint num, input longint den);
    longint q;
    q = num / den;
    if ((num % den != 0) && (num < 0)) q = q - 1;
    return q;
  endfunction

  function automatic int axis_hundredths(input logic [7:0] t, input logic [7:0] o,
                                         input logic [7:0] f, input logic [7:0] h);
    return (int'(t) - ASCII_ZERO) * 1000 + (int'(o) - ASCII_ZERO) * 100 +
           (int'(f) - ASCII_ZERO) * 10 + (int'(h) - ASCII_ZERO);
  endfunction

  function automatic void filter_axis(input int ax, input int sample,
                                      output int pos_avg, output int vel_avg);
    longint psum;
    longint vsum;
    longint diff;
    longint raw;
    psum = sample;
    for (int i = PTAPS - 1; i > 0; i--) begin
      pos_win[ax][i] = pos_win[ax][i-1];
      psum += pos_win[ax][i];
    end
    pos_win[ax][0] = sample;
    pos_avg = int'(floor_div(psum * FRAC_SCALE, PTAPS));
    diff = longint'(pos_avg) - longint'(prev_avg[ax]);
    raw = floor_div(diff * longint'(rate_scale), FRAC_SCALE);
    if (raw > VEL_MAX) begin
      raw = VEL_MAX;
      saturated++;
    end
    if (raw < VEL_MIN) begin
      raw = VEL_MIN;
      saturated++;
    end
    prev_avg[ax] = pos_avg;
    vsum = raw;
    for (int i = VTAPS - 1; i > 0; i--) begin
      vel_win[ax][i] = vel_win[ax][i-1];
      vsum += vel_win[ax][i];
    end
    vel_win[ax][0] = int'(raw);
    vel_avg = int'(floor_div(vsum, VTAPS));
  endfunction

  task automatic predict_estimate(input in_item_t f);
    int xa;
    int xv;
    int ya;
    int yv;
    out_item_t e;
    filter_axis(AXIS_X, axis_hundredths(f.x_tens_char, f.x_ones_char, f.x_tenths_char,
                                        f.x_hundredths_char), xa, xv);
    filter_axis(AXIS_Y, axis_hundredths(f.y_tens_char, f.y_ones_char, f.y_tenths_char,
                                        f.y_hundredths_char), ya, yv);
    e.x_position_avg = xa[AVG_W-1:0];
    e.y_position_avg = ya[AVG_W-1:0];
    e.x_velocity_avg = xv;
    e.y_velocity_avg = yv;
    estimate_queue.push_back(e);
  endtask

  task automatic compare_field(input string name, input logic signed [63:0] got,
                               input logic signed [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s of estimate %0d is %0d, expected %0d",
                                name, checked, got, want));
  endtask

  task automatic check_estimate(input out_item_t got);
    out_item_t want;
    if (estimate_queue.size() == 0) begin
      report_mismatch($sformatf("estimate with no frame pending, x %0d y %0d",
                                got.x_position_avg, got.y_position_avg));
      return;
    end
    want = estimate_queue.pop_front();
    compare_field("x_position_avg", got.x_position_avg, want.x_position_avg);
    compare_field("y_position_avg", got.y_position_avg, want.y_position_avg);
    compare_field("x_velocity_avg", got.x_velocity_avg, want.x_velocity_avg);
    compare_field("y_velocity_avg", got.y_velocity_avg, want.y_velocity_avg);
    checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (pos_win[a, i]) pos_win[a][i] = 0;
      foreach (vel_win[a, i]) vel_win[a][i] = 0;
      prev_avg[AXIS_X] = 0;
      prev_avg[AXIS_Y] = 0;
      rate_scale = SCALE_RESET;
      estimate_queue.delete();
    end else begin
      if (psel && penable && pready && paddr[CFG_ADDR_W-1:CFG_IDX_BIT] == REG_SCALE) begin
        if (pwrite) rate_scale = pwdata[SCALE_W-1:0];
        else if (prdata !== APB_DATA_W'(rate_scale))
          report_mismatch($sformatf("scale read back as %0d, expected %0d",
                                    prdata, rate_scale));
      end
      if (in_valid && in_ready && in_data.frame_tag == TAG_X) predict_estimate(in_data);
      if (out_valid && out_ready) check_estimate(out_data);
    end
    outstanding <= estimate_queue.size();
    mismatch_count <= errors;
    estimates_checked <= checked;
    saturated_samples <= saturated;
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the estimator testbench: clock, reset, frame and register stimulus and the verdict.
// Depends on apve_pkg, the estimator RTL and apve_estimate_checker.
module tb_top;
  import apve_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam int CHUNK_FRAMES = 62;
  localparam int ASCII_ZERO = 48;
  localparam int SPARE_REG_IDX = 1;
  localparam logic [CHAR_W-1:0] TAG_T = 8'd84;
  localparam logic [CHAR_W-1:0] TAG_M = 8'd77;
  localparam logic [CFG_ADDR_W-1:0] SCALE_ADDR = CFG_ADDR_W'(REG_SCALE) << CFG_IDX_BIT;
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = CFG_ADDR_W'(SPARE_REG_IDX << CFG_IDX_BIT);

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatch_count;
  int outstanding;
  int estimates_checked;
  int saturated_samples;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int take_idle_pct = 0;
  int frames_sent = 0;
  int x_frames_sent = 0;
  int scale_writes = 0;
  int walk_x = 5000;
  int walk_y = 5000;

  ascii_position_velocity_estimator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  apve_estimate_checker checker_inst (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .mismatch_count(mismatch_count), .outstanding(outstanding),
    .estimates_checked(estimates_checked), .saturated_samples(saturated_samples)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= take_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d estimates pending.", cycle_count, outstanding);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic in_item_t coded_frame(input logic [CHAR_W-1:0] tag, input int xh,
                                           input int yh);
    in_item_t f;
    f.frame_tag = tag;
    f.x_tens_char = 8'(ASCII_ZERO + xh / 1000);
    f.x_ones_char = 8'(ASCII_ZERO + (xh / 100) % 10);
    f.x_tenths_char = 8'(ASCII_ZERO + (xh / 10) % 10);
    f.x_hundredths_char = 8'(ASCII_ZERO + xh % 10);
    f.y_tens_char = 8'(ASCII_ZERO + yh / 1000);
    f.y_ones_char = 8'(ASCII_ZERO + (yh / 100) % 10);
    f.y_tenths_char = 8'(ASCII_ZERO + (yh / 10) % 10);
    f.y_hundredths_char = 8'(ASCII_ZERO + yh % 10);
    return f;
  endfunction

  function automatic in_item_t uniform_frame(input logic [CHAR_W-1:0] tag,
                                             input logic [CHAR_W-1:0] b);
    return in_item_t'({tag, {8{b}}});
  endfunction

  function automatic in_item_t random_bytes();
    in_item_t f;
    for (int i = 0; i < 9; i++) f[i*CHAR_W +: CHAR_W] = 8'($urandom);
    return f;
  endfunction

  function automatic logic [CHAR_W-1:0] boundary_byte();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'(ASCII_ZERO);
      default: return 8'(ASCII_ZERO + 9);
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] foreign_tag();
    logic [CHAR_W-1:0] tag;
    case ($urandom_range(2))
      0: tag = TAG_T;
      1: tag = TAG_M;
      default: begin
        do tag = 8'($urandom); while (tag == TAG_X);
      end
    endcase
    return tag;
  endfunction

  function automatic int drift(input int v);
    int n;
    n = v + int'($urandom_range(200)) - 100;
    if (n < 0) n = 0;
    if (n > 9999) n = 9999;
    return n;
  endfunction

  function automatic logic [SCALE_W-1:0] scale_for_chunk(input int n);
    case (n)
      0: return 16'd1;
      2: return SCALE_RESET;
      3: return 16'hFFFF;
      5: return 16'd0;
      7: return 16'd256;
      default: return 16'($urandom_range(65535, 1));
    endcase
  endfunction

  task automatic send_frame(input in_item_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frames_sent++;
    if (f.frame_tag == TAG_X) x_frames_sent++;
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_transfer(input logic write, input logic [CFG_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_scale(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [SCALE_W-1:0] value);
    wait_until_drained();
    apb_transfer(1'b1, addr, APB_DATA_W'(value));
    apb_transfer(1'b0, SCALE_ADDR, '0);
    scale_writes++;
  endtask

  task automatic run_directed();
    send_frame(coded_frame(TAG_X, 0, 0));
    send_frame(coded_frame(TAG_X, 9999, 9999));
    send_frame(uniform_frame(TAG_X, 8'h00));
    send_frame(uniform_frame(TAG_X, 8'hFF));
    send_frame(uniform_frame(TAG_T, 8'hFF));
    send_frame(uniform_frame(TAG_M, 8'h00));
    send_frame(uniform_frame(8'h00, 8'h5A));
    send_frame(uniform_frame(8'hFF, 8'hA5));
    send_frame(uniform_frame(TAG_X - 8'd1, 8'hFF));
    send_frame(uniform_frame(TAG_X + 8'd1, 8'h00));
    send_frame(in_item_t'({TAG_X, {4{8'hFF}}, {4{8'h00}}}));
    send_frame(coded_frame(TAG_X, 1234, 5678));
    write_scale(SCALE_ADDR, 16'hFFFF);
    for (int i = 0; i < 6; i++) send_frame(uniform_frame(TAG_X, (i % 2) ? 8'h00 : 8'hFF));
    write_scale(SPARE_ADDR, 16'd1);
    send_frame(uniform_frame(TAG_X, 8'hFF));
    send_frame(uniform_frame(TAG_X, 8'h00));
    write_scale(SCALE_ADDR, 16'd0);
    send_frame(coded_frame(TAG_X, 9999, 0));
    send_frame(coded_frame(TAG_X, 0, 9999));
    send_frame(uniform_frame(TAG_X, 8'hFF));
  endtask

  task automatic run_random(input int x_frames);
    int sent;
    int pick;
    in_item_t f;
    sent = 0;
    while (sent < x_frames) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        walk_x = drift(walk_x);
        walk_y = drift(walk_y);
        f = coded_frame(TAG_X, walk_x, walk_y);
      end else if (pick < 65) begin
        f = coded_frame(TAG_X, $urandom_range(9999), $urandom_range(9999));
      end else if (pick < 75) begin
        f = random_bytes();
        f.frame_tag = TAG_X;
      end else if (pick < 82) begin
        for (int i = 0; i < 8; i++) f[i*CHAR_W +: CHAR_W] = boundary_byte();
        f.frame_tag = TAG_X;
      end else begin
        f = random_bytes();
        f.frame_tag = foreign_tag();
      end
      send_frame(f);
      if (f.frame_tag == TAG_X) sent++;
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 26;
          take_idle_pct = 72;
        end
        1: begin
          send_idle_pct = 72;
          take_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          take_idle_pct = 0;
        end
      endcase
      for (int chunk = 0; chunk < 3; chunk++) begin
        write_scale(SCALE_ADDR, scale_for_chunk(phase * 3 + chunk));
        run_random(CHUNK_FRAMES);
      end
    end
    wait_until_drained();
    $display("Sent %0d frames, %0d of them tagged X, across %0d scale writes",
             frames_sent, x_frames_sent, scale_writes);
    $display("and three idle patterns; compared %0d estimates, %0d velocity samples saturated.",
             estimates_checked, saturated_samples);
    if (mismatch_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
